@@ sv/ipt_pkg.sv @@
// Shared types and constants of the inverted page table with FIFO replacement.
// Holds field widths, register indexes, reset values and controller structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipt_pkg;

  localparam int PID_W       = 16;
  localparam int PAGE_W      = 16;
  localparam int OFS_W       = 10;
  localparam int FNUM_W      = 6;
  localparam int PA_W        = 16;
  localparam int FS_W        = 11;
  localparam int FIU_W       = 7;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WORDS   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = CFG_INDEX_W'(1);

  localparam int RESET_MEM_WORDS   = 500;
  localparam int RESET_FRAME_WORDS = 10;
  localparam logic [FS_W-1:0]  FRAME_WORDS_RESET   = FS_W'(RESET_FRAME_WORDS);
  localparam logic [FIU_W-1:0] FRAMES_IN_USE_RESET = FIU_W'(RESET_MEM_WORDS / RESET_FRAME_WORDS);

  typedef struct packed {
    logic ready_in;
    logic load;
    logic step;
    logic hit_set;
    logic retire;
  } ipt_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic offset_bad;
    logic empty;
    logic match;
    logic last;
    logic out_free;
  } ipt_status_t;

endpackage

`default_nettype wire

@@ sv/ipt_if.sv @@
// Channel interfaces: request, result and configuration write.
// Depends on ipt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ipt_req_if;
  import ipt_pkg::*;
  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  process_id;
  logic [PAGE_W-1:0] virtual_page;
  logic [OFS_W-1:0]  page_offset;
  modport source (output valid, output process_id, output virtual_page,
                  output page_offset, input ready);
  modport sink   (input valid, input process_id, input virtual_page,
                  input page_offset, output ready);
endinterface

interface ipt_res_if;
  import ipt_pkg::*;
  logic              valid;
  logic              ready;
  logic [FNUM_W-1:0] frame_number;
  logic [PA_W-1:0]   physical_address;
  logic              hit;
  logic              evicted;
  logic              invalid;
  modport source (output valid, output frame_number, output physical_address,
                  output hit, output evicted, output invalid, input ready);
  modport sink   (input valid, input frame_number, input physical_address,
                  input hit, input evicted, input invalid, output ready);
endinterface

interface ipt_cfg_if;
  import ipt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/ipt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/ipt_ctrl.sv @@
// Controller of the page table: accept, scan the filled frames, retire.
// Depends on ipt_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ipt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ipt_pkg::ipt_status_t st,
  output ipt_pkg::ipt_cmd_t    cmd
);
  import ipt_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.ready_in = 1'b1;
        if (st.in_valid) begin
          cmd.load = 1'b1;
          if (st.offset_bad || st.empty) begin
            state_next = FINISH;
          end else begin
            state_next = SEARCH;
          end
        end
      end
      SEARCH: begin
        if (st.match) begin
          cmd.hit_set = 1'b1;
          state_next  = FINISH;
        end else if (st.last) begin
          state_next = FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      FINISH: begin
        if (st.out_free) begin
          cmd.retire = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/ipt_datapath.sv @@
// Datapath of the page table: config registers, key store, scan index,
// fill count, FIFO pointer and result register.
// Depends on ipt_pkg, ipt_if and ipt_ram.
`timescale 1ns / 1ps
`default_nettype none

module ipt_datapath #(
  parameter int MAX_FRAMES = 64,
  parameter int ID_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  ipt_req_if.sink              req,
  ipt_res_if.source            res,
  ipt_cfg_if.sink              cfg,
  input  ipt_pkg::ipt_cmd_t    cmd,
  output ipt_pkg::ipt_status_t st
);
  import ipt_pkg::*;

  localparam int FRAME_W = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int NW      = (CNT_W > FIU_W) ? CNT_W : FIU_W;
  localparam int ID_W    = (ID_BITS < PID_W) ? ID_BITS : PID_W;
  localparam int KEY_W   = 2 * ID_W;
  localparam int PROD_W  = FRAME_W + FS_W + 1;

  logic [FS_W-1:0]    frame_words;
  logic [FIU_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]   filled;
  logic [FRAME_W-1:0] oldest;

  logic [ID_W-1:0]    key_pid;
  logic [ID_W-1:0]    key_page;
  logic [OFS_W-1:0]   key_offset;
  logic               inv;
  logic               hit;
  logic [FRAME_W-1:0] hit_idx;
  logic [FRAME_W-1:0] scan_idx;

  logic               out_valid;
  logic [FNUM_W-1:0]  out_frame;
  logic [PA_W-1:0]    out_addr;
  logic               out_hit;
  logic               out_evicted;
  logic               out_invalid;

  logic [NW-1:0]      fiu_ext;
  logic [CNT_W-1:0]   n_active;
  logic               full;
  logic [FRAME_W-1:0] frame;
  logic [FRAME_W-1:0] oldest_next;
  logic [PROD_W-1:0]  prod;
  logic               table_we;
  logic [FRAME_W-1:0] raddr;
  logic [KEY_W-1:0]   rdata;

  always_comb begin
    fiu_ext = NW'(frames_in_use);
    if (fiu_ext == '0) begin
      n_active = CNT_W'(1);
    end else if (fiu_ext > NW'(MAX_FRAMES)) begin
      n_active = CNT_W'(MAX_FRAMES);
    end else begin
      n_active = CNT_W'(fiu_ext);
    end
  end

  always_comb begin
    full        = !(filled < n_active);
    oldest_next = '0;
    if (hit) begin
      frame = hit_idx;
    end else if (!full) begin
      frame = FRAME_W'(filled);
    end else if (CNT_W'(oldest) >= n_active) begin
      frame = '0;
    end else begin
      frame = oldest;
    end
    if (CNT_W'(frame) + CNT_W'(1) < n_active) begin
      oldest_next = frame + FRAME_W'(1);
    end
    prod = PROD_W'(frame) * PROD_W'(frame_words) + PROD_W'(key_offset);
  end

  assign table_we = cmd.retire && !inv && !hit;
  assign raddr    = cmd.load ? '0 : scan_idx + FRAME_W'(1);

  ipt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_FRAMES)
  ) u_keys (
    .clk   (clk),
    .we    (table_we),
    .waddr (frame),
    .wdata ({key_pid, key_page}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign st.in_valid   = req.valid;
  assign st.offset_bad = FS_W'(req.page_offset) >= frame_words;
  assign st.empty      = filled == '0;
  assign st.match      = rdata == {key_pid, key_page};
  assign st.last       = CNT_W'(scan_idx) + CNT_W'(1) == filled;
  assign st.out_free   = !out_valid || res.ready;

  assign req.ready = cmd.ready_in;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words   <= FRAME_WORDS_RESET;
      frames_in_use <= FRAMES_IN_USE_RESET;
      filled        <= '0;
      oldest        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.index == REG_FRAME_WORDS) begin
        frame_words <= cfg.data[FS_W-1:0];
      end
      if (cfg.valid && cfg.index == REG_FRAMES_IN_USE) begin
        frames_in_use <= cfg.data[FIU_W-1:0];
        filled        <= '0;
        oldest        <= '0;
      end else if (table_we) begin
        if (!full) begin
          filled <= filled + CNT_W'(1);
        end else begin
          oldest <= oldest_next;
        end
      end
      if (cmd.retire) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_pid    <= req.process_id[ID_W-1:0];
      key_page   <= req.virtual_page[ID_W-1:0];
      key_offset <= req.page_offset;
      inv        <= st.offset_bad;
      hit        <= 1'b0;
      scan_idx   <= '0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + FRAME_W'(1);
    end else if (cmd.hit_set) begin
      hit     <= 1'b1;
      hit_idx <= scan_idx;
    end
    if (cmd.retire) begin
      out_frame   <= inv ? '0 : FNUM_W'(frame);
      out_addr    <= inv ? '0 : PA_W'(prod);
      out_hit     <= !inv && hit;
      out_evicted <= !inv && !hit && full;
      out_invalid <= inv;
    end
  end

  assign res.valid            = out_valid;
  assign res.frame_number     = out_frame;
  assign res.physical_address = out_addr;
  assign res.hit              = out_hit;
  assign res.evicted          = out_evicted;
  assign res.invalid          = out_invalid;

endmodule

`default_nettype wire

@@ sv/inverted_page_table_fifo_top.sv @@
// Top level of the inverted page table with FIFO replacement.
// Depends on ipt_pkg, ipt_if, ipt_ctrl and ipt_datapath.
//
//   channel | dir | payload                                             | accepted when
//   req     | in  | process_id, virtual_page, page_offset               | valid && ready
//   res     | out | frame_number, physical_address, hit, evicted, inv.  | valid && ready
//   cfg     | in  | index (0 frame words, 1 frames in use), data        | valid (ready = 1)
//
// A miss is accepted, then scans every filled frame in turn through the single
// read port of the key RAM, then retires; a hit at frame f stops the scan
// there. Offset errors and an empty table skip the scan and go straight from
// accept to retire. Retire stalls while the previous result is unread.
// Reset is synchronous; it empties the table through the fill count, no sweep.
// A result waits in the output register; a new request is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module inverted_page_table_fifo_top #(
  parameter int MAX_FRAMES = 64,
  parameter int ID_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  ipt_req_if.sink   req,
  ipt_res_if.source res,
  ipt_cfg_if.sink   cfg
);
  import ipt_pkg::*;

  ipt_cmd_t    cmd;
  ipt_status_t st;

  ipt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  ipt_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cfg (cfg),
    .cmd (cmd),
    .st  (st)
  );

endmodule

`default_nettype wire
